// ===== sv/jsu_pkg.sv =====
// Shared types, codes and helpers for the JSON string unescape unit.
// Used by jsu_decode, json_string_unescape_unit and jsu_checker.
`default_nettype none
package jsu_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_WAIT = 2'd0,
    PH_STR  = 2'd1,
    PH_ESC  = 2'd2,
    PH_HEX  = 2'd3
  } phase_t;

  // Result kind codes as they appear on the kind port
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_DONE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // Character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LOW_B = 8'h62;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_LOW_N = 8'h6E;
  localparam logic [7:0] CH_LOW_R = 8'h72;
  localparam logic [7:0] CH_LOW_T = 8'h74;
  localparam logic [7:0] CH_LOW_U = 8'h75;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] BS_CODE = 8'h08;
  localparam logic [7:0] FF_CODE = 8'h0C;
  localparam logic [7:0] LF_CODE = 8'h0A;
  localparam logic [7:0] CR_CODE = 8'h0D;
  localparam logic [7:0] TAB_CODE = 8'h09;

  // Parser state carried between items
  typedef struct packed {
    phase_t      phase;
    logic [1:0]  hex_count;
    logic [15:0] code_unit;
  } jsu_state_t;

  // Results caused by one item: cnt of 0..3, all of one kind
  typedef struct packed {
    logic [1:0]      cnt;
    logic [1:0]      kind;
    logic [2:0][7:0] bytes;
  } jsu_result_t;

  // Hex digit decode
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage
`default_nettype wire

// ===== sv/jsu_decode.sv =====
// Combinational decode of one input item against the parser state.
// Depends on jsu_pkg for state, result and code definitions.
`default_nettype none
module jsu_decode
  import jsu_pkg::*;
(
  input  wire jsu_state_t  state,
  input  wire logic [7:0]  in_byte,
  input  wire logic        end_of_input,
  output jsu_state_t       state_next,
  output jsu_result_t      result
);

  hex_digit_t  hd;
  logic [15:0] cu;

  assign hd = hex_decode(in_byte);
  assign cu = {state.code_unit[11:0], hd.val};

  always_comb begin
    state_next   = state;
    result.cnt   = 2'd0;
    result.kind  = KIND_DATA;
    result.bytes = '0;

    case (state.phase)
      // Inside the string body
      PH_STR: begin
        if (end_of_input || in_byte < CH_SPACE) begin
          state_next.phase     = PH_WAIT;
          state_next.hex_count = 2'd0;
          result.cnt           = 2'd1;
          result.kind          = KIND_ERR;
        end else if (in_byte == CH_QUOTE) begin
          state_next.phase = PH_WAIT;
          result.cnt       = 2'd1;
          result.kind      = KIND_DONE;
        end else if (in_byte == CH_BSLASH) begin
          state_next.phase = PH_ESC;
        end else begin
          result.cnt      = 2'd1;
          result.bytes[0] = in_byte;
        end
      end

      // Byte after a backslash
      PH_ESC: begin
        result.cnt = 2'd1;
        state_next.phase = PH_STR;
        case (in_byte)
          CH_QUOTE:  result.bytes[0] = CH_QUOTE;
          CH_BSLASH: result.bytes[0] = CH_BSLASH;
          CH_SLASH:  result.bytes[0] = CH_SLASH;
          CH_LOW_B:  result.bytes[0] = BS_CODE;
          CH_LOW_F:  result.bytes[0] = FF_CODE;
          CH_LOW_N:  result.bytes[0] = LF_CODE;
          CH_LOW_R:  result.bytes[0] = CR_CODE;
          CH_LOW_T:  result.bytes[0] = TAB_CODE;
          CH_LOW_U: begin
            result.cnt           = 2'd0;
            state_next.phase     = PH_HEX;
            state_next.hex_count = 2'd0;
            state_next.code_unit = 16'd0;
          end
          default: begin
            state_next.phase     = PH_WAIT;
            state_next.hex_count = 2'd0;
            result.kind          = KIND_ERR;
          end
        endcase
        // End of input overrides whatever the byte looked like
        if (end_of_input) begin
          state_next           = state;
          state_next.phase     = PH_WAIT;
          state_next.hex_count = 2'd0;
          result.cnt           = 2'd1;
          result.kind          = KIND_ERR;
          result.bytes         = '0;
        end
      end

      // Gather four hex digits, then encode as UTF-8
      PH_HEX: begin
        if (end_of_input || !hd.ok) begin
          state_next.phase     = PH_WAIT;
          state_next.hex_count = 2'd0;
          result.cnt           = 2'd1;
          result.kind          = KIND_ERR;
        end else begin
          state_next.code_unit = cu;
          if (state.hex_count == 2'd3) begin
            state_next.hex_count = 2'd0;
            state_next.phase     = PH_STR;
            if (cu[15:7] == 9'd0) begin
              result.cnt      = 2'd1;
              result.bytes[0] = cu[7:0];
            end else if (cu[15:11] == 5'd0) begin
              result.cnt      = 2'd2;
              result.bytes[0] = {3'b110, cu[10:6]};
              result.bytes[1] = {2'b10, cu[5:0]};
            end else begin
              result.cnt      = 2'd3;
              result.bytes[0] = {4'b1110, cu[15:12]};
              result.bytes[1] = {2'b10, cu[11:6]};
              result.bytes[2] = {2'b10, cu[5:0]};
            end
          end else begin
            state_next.hex_count = state.hex_count + 2'd1;
          end
        end
      end

      // Waiting for the opening quote
      default: begin
        if (!end_of_input && in_byte == CH_QUOTE) begin
          state_next.phase     = PH_STR;
          state_next.hex_count = 2'd0;
        end else begin
          state_next.phase     = PH_WAIT;
          state_next.hex_count = 2'd0;
          result.cnt           = 2'd1;
          result.kind          = KIND_ERR;
        end
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/json_string_unescape_unit.sv =====
// JSON string unescape unit: input register, decode, result group register.
// Depends on jsu_pkg and jsu_decode.
//
// Usage: send a quoted JSON string one byte per item on the input channel
// (in_valid, in_stall, in_byte, end_of_input), opening quote first. Each
// result item on the output channel (out_valid, out_stall, out_byte, kind,
// last) is a decoded byte (kind 0), string complete (kind 1) or syntax error
// (kind 2); last marks the final result of one input item.
// Path: an item is registered at the input and decoded combinationally;
// its first result enters the group register when the item advances and
// shows on the ports straight from that register.
// Throughput: one item per cycle while the receiver does not stall and each
// item gives at most one result; an item whose \uXXXX escape expands to two
// or three UTF-8 bytes holds the group register until all its bytes are
// taken, since the output port moves one result per cycle. Items that give
// no result never wait on the output side.
// Reset clears the parser to waiting for an opening quote and empties both
// registers. When the receiver stalls, the current result holds; the input
// register keeps taking items until it is full and its decoded results
// cannot enter the group register.
`default_nettype none
module json_string_unescape_unit
  import jsu_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_input,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      kind,
  output logic            last
);

  // Input register
  logic       iv;
  logic [7:0] ib;
  logic       ie;

  // Parser state
  jsu_state_t  state;
  jsu_state_t  state_next;
  jsu_result_t res;

  // Result group register
  logic            g_valid;
  logic [1:0]      g_cnt;
  logic [1:0]      g_idx;
  logic [1:0]      g_kind;
  logic [2:0][7:0] g_bytes;

  logic g_last;
  logic out_take;
  logic g_free;
  logic advance;

  jsu_decode u_decode (
    .state        (state),
    .in_byte      (ib),
    .end_of_input (ie),
    .state_next   (state_next),
    .result       (res)
  );

  assign g_last   = (g_idx == g_cnt - 2'd1);
  assign out_take = g_valid && !out_stall;
  assign g_free   = !g_valid || (out_take && g_last);
  assign advance  = iv && ((res.cnt == 2'd0) || g_free);
  assign in_stall = iv && !advance;

  assign out_valid = g_valid;
  assign out_byte  = g_bytes[g_idx];
  assign kind      = g_kind;
  assign last      = g_last;

  // Load the input register whenever it is empty or moving on
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (!in_stall) begin
      iv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      ib <= in_byte;
      ie <= end_of_input;
    end
  end

  // Advance the parser when the registered item is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase     <= PH_WAIT;
      state.hex_count <= 2'd0;
      state.code_unit <= 16'd0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Fill, step through and drain the result group
  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
      g_idx   <= 2'd0;
    end else if (advance && res.cnt != 2'd0) begin
      g_valid <= 1'b1;
      g_idx   <= 2'd0;
    end else if (out_take && g_last) begin
      g_valid <= 1'b0;
      g_idx   <= 2'd0;
    end else if (out_take) begin
      g_idx <= g_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.cnt != 2'd0) begin
      g_cnt   <= res.cnt;
      g_kind  <= res.kind;
      g_bytes <= res.bytes;
    end
  end

endmodule
`default_nettype wire

// ===== sv/jsu_checker.sv =====
// Port-level checks for json_string_unescape_unit, attached by bind.
// Depends on jsu_pkg for the result kind codes.
`default_nettype none
module jsu_port_checks
  import jsu_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic [1:0] kind,
  input wire logic       last
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(kind) &&
      $stable(last))
    else $error("stalled result changed");

  // Done and error stand alone as the last result of their item
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> last)
    else $error("status result not marked last");

  // Status results carry a zero byte
  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_DATA |-> out_byte == 8'd0)
    else $error("status result carries a byte");

  // Drop all results at reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result visible after reset");

endmodule

bind json_string_unescape_unit jsu_port_checks u_jsu_port_checks (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .kind      (kind),
  .last      (last)
);
`default_nettype wire
